FILE: src/gkm_pkg.sv
// ---------------------------------------------------------------------------
// gkm_pkg
// Shared types and constants for the greedy mixture merge block.
// ---------------------------------------------------------------------------
package gkm_pkg;

  typedef enum logic [1:0] {
    ACT_LOAD_OLD = 2'd0,
    ACT_LOAD_NEW = 2'd1,
    ACT_START    = 2'd2,
    ACT_NONE     = 2'd3
  } action_e;

  localparam logic [1:0] CFG_OLD_COUNT  = 2'd0;
  localparam logic [1:0] CFG_NEW_COUNT  = 2'd1;
  localparam logic [1:0] CFG_COMPONENTS = 2'd2;
  localparam logic [1:0] CFG_DIMS       = 2'd3;

  localparam int MEAN_W = 32;
  localparam int VAR_W  = 32;
  localparam int WGT_W  = 17;
  localparam int CNT_W  = 24;
  localparam int SIZE_W = 4;
  localparam int KL_W   = 48;
  localparam int LOG_W  = 21;
  localparam int DIV_NW = 64;
  localparam int DIV_DW = 41;
  localparam int F_W    = 25;

  localparam logic [KL_W-1:0]  KL_CAP   = 48'h7FFF_FFFF_FFFF;
  localparam logic [15:0]      LN2_Q16  = 16'd45426;
  localparam logic [WGT_W-1:0] ONE_Q16  = 17'h10000;
  localparam logic [F_W-1:0]   HALF_Q24 = 25'h080_0000;

  typedef enum logic [1:0] {
    DOP_A = 2'd0,  // variance ratio
    DOP_B = 2'd1,  // squared mean distance over variance
    DOP_F = 2'd2,  // share of the new component
    DOP_W = 2'd3   // merged weight
  } div_op_e;

  typedef struct packed {
    logic    ld_old;
    logic    ld_new;
    logic    run_init;
    logic    elem_rd;
    logic    elem_best;
    logic    div_go;
    div_op_e div_op;
    logic    acc_add_div;
    logic    log_go;
    logic    log_sel_s1;
    logic    log1_lat;
    logic    c_mul;
    logic    acc_add_c;
    logic    tab_wr;
    logic    srch_clr;
    logic    tab_rd;
    logic    take;
    logic    mul_w;
    logic    sum_s;
    logic    f_half;
    logic    f_lat;
    logic    w_zero;
    logic    w_lat;
    logic    prod_mul;
    logic    out_load;
    logic    out_last;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic log_done;
    logic s_zero;
    logic cnt_zero;
    logic out_free;
  } status_t;

endpackage

FILE: src/gkm_div.sv
// ---------------------------------------------------------------------------
// gkm_div
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module gkm_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [gkm_pkg::DIV_NW-1:0]       num_i,
  input  logic [gkm_pkg::DIV_DW-1:0]       den_i,
  output logic                             done_o,
  output logic [gkm_pkg::DIV_NW-1:0]       quot_o
);

  localparam int NW = gkm_pkg::DIV_NW;
  localparam int DW = gkm_pkg::DIV_DW;
  localparam int CW = $clog2(NW + 1);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] rem_q, den_q;
  logic [NW-1:0] quo_q;

  logic [DW:0]   rem_sh;
  logic [DW+1:0] diff;

  assign rem_sh = {rem_q, quo_q[NW-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      den_q <= den_i;
      quo_q <= num_i;
    end else if (busy_q) begin
      if (!diff[DW+1]) begin
        rem_q <= diff[DW-1:0];
        quo_q <= {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[DW-1:0];
        quo_q <= {quo_q[NW-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

FILE: src/gkm_log2.sv
// ---------------------------------------------------------------------------
// gkm_log2
// Base-two logarithm in unsigned Q5.16: bit-wise normalize, then sixteen squarings.
// ---------------------------------------------------------------------------
module gkm_log2 (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [gkm_pkg::VAR_W-1:0]     x_i,
  output logic                          done_o,
  output logic [gkm_pkg::LOG_W-1:0]     result_o
);

  typedef enum logic [1:0] {
    L_IDLE,
    L_NORM,
    L_MUL,
    L_ADJ
  } lstate_e;

  lstate_e     state_q;
  logic        done_q;
  logic [3:0]  it_q;
  logic [4:0]  p_q;
  logic [15:0] frac_q;
  logic [32:0] y_q, prod_q;
  logic [63:0] sq;

  assign sq = 64'(y_q[31:0]) * 64'(y_q[31:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      done_q  <= 1'b0;
      it_q    <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        L_IDLE: begin
          if (start_i) state_q <= L_NORM;
        end
        L_NORM: begin
          if (y_q[31]) begin
            state_q <= L_MUL;
            it_q    <= '0;
          end
        end
        L_MUL: begin
          state_q <= L_ADJ;
        end
        L_ADJ: begin
          if (it_q == 4'd15) begin
            state_q <= L_IDLE;
            done_q  <= 1'b1;
          end else begin
            it_q    <= it_q + 1'b1;
            state_q <= L_MUL;
          end
        end
        default: state_q <= L_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      L_IDLE: begin
        if (start_i) begin
          y_q    <= (x_i == '0) ? 33'd1 : {1'b0, x_i};
          p_q    <= 5'd31;
          frac_q <= '0;
        end
      end
      L_NORM: begin
        if (!y_q[31]) begin
          y_q <= {y_q[31:0], 1'b0};
          p_q <= p_q - 1'b1;
        end
      end
      L_MUL: begin
        prod_q <= sq[63:31];
      end
      L_ADJ: begin
        frac_q <= {frac_q[14:0], prod_q[32]};
        y_q    <= prod_q[32] ? {1'b0, prod_q[32:1]} : prod_q;
      end
      default: ;
    endcase
  end

  assign done_o   = done_q;
  assign result_o = {p_q, frac_q};

endmodule

FILE: src/gkm_dp.sv
// ---------------------------------------------------------------------------
// gkm_dp
// Datapath: mixture stores, divergence table, arithmetic units, result beat.
// ---------------------------------------------------------------------------
module gkm_dp #(
  parameter int MAX_COMPONENTS = 8,
  parameter int MAX_DIMS       = 8,
  localparam int CW  = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1,
  localparam int DIW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  gkm_pkg::cmd_t                      cmd_i,
  input  logic [CW-1:0]                      ci_i,
  input  logic [CW-1:0]                      cj_i,
  input  logic [CW-1:0]                      ck_i,
  input  logic [DIW-1:0]                     cd_i,
  output gkm_pkg::status_t                   status_o,
  output logic [CW-1:0]                      k_last_o,
  output logic [DIW-1:0]                     d_last_o,
  input  logic                               cfg_we_i,
  input  logic [1:0]                         cfg_index_i,
  input  logic [gkm_pkg::CNT_W-1:0]          cfg_data_i,
  input  logic [2:0]                         component_i,
  input  logic [2:0]                         dimension_i,
  input  logic signed [gkm_pkg::MEAN_W-1:0]  mean_i,
  input  logic [gkm_pkg::VAR_W-1:0]          variance_i,
  input  logic [gkm_pkg::WGT_W-1:0]          weight_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [2:0]                         merged_index_o,
  output logic [2:0]                         out_dimension_o,
  output logic signed [gkm_pkg::MEAN_W-1:0]  merged_mean_o,
  output logic [gkm_pkg::VAR_W-1:0]          merged_variance_o,
  output logic [gkm_pkg::WGT_W-1:0]          merged_weight_o,
  output logic                               last_o
);

  localparam int EDEP = MAX_COMPONENTS * MAX_DIMS;
  localparam int EAW  = (EDEP > 1) ? $clog2(EDEP) : 1;
  localparam int TDEP = MAX_COMPONENTS * MAX_COMPONENTS;
  localparam int TAW  = (TDEP > 1) ? $clog2(TDEP) : 1;
  localparam int MW   = gkm_pkg::MEAN_W;
  localparam int VW   = gkm_pkg::VAR_W;
  localparam int WW   = gkm_pkg::WGT_W;
  localparam int KW   = gkm_pkg::KL_W;
  localparam int LW   = gkm_pkg::LOG_W;
  localparam int FW   = gkm_pkg::F_W;
  localparam int NW   = gkm_pkg::DIV_NW;
  localparam int DDW  = gkm_pkg::DIV_DW;
  localparam int CNT_W1 = gkm_pkg::CNT_W + 1;

  function automatic logic signed [KW-1:0] cap_add(input logic signed [KW-1:0] a,
                                                   input logic signed [KW-1:0] t);
    logic signed [KW:0] s;
    s = $signed({a[KW-1], a}) + $signed({t[KW-1], t});
    if (s > $signed({1'b0, gkm_pkg::KL_CAP})) return $signed(gkm_pkg::KL_CAP);
    return s[KW-1:0];
  endfunction

  // configuration
  logic [gkm_pkg::CNT_W-1:0]  old_count_q, new_count_q;
  logic [gkm_pkg::SIZE_W-1:0] comps_q, dims_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      old_count_q <= '0;
      new_count_q <= '0;
      comps_q     <= 4'd8;
      dims_q      <= 4'd8;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        gkm_pkg::CFG_OLD_COUNT:  old_count_q <= cfg_data_i;
        gkm_pkg::CFG_NEW_COUNT:  new_count_q <= cfg_data_i;
        gkm_pkg::CFG_COMPONENTS: comps_q     <= cfg_data_i[gkm_pkg::SIZE_W-1:0];
        gkm_pkg::CFG_DIMS:       dims_q      <= cfg_data_i[gkm_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (comps_q == '0) k_last_o = '0;
    else if (32'(comps_q) > MAX_COMPONENTS) k_last_o = CW'(MAX_COMPONENTS - 1);
    else k_last_o = CW'(comps_q - 1'b1);
    if (dims_q == '0) d_last_o = '0;
    else if (32'(dims_q) > MAX_DIMS) d_last_o = DIW'(MAX_DIMS - 1);
    else d_last_o = DIW'(dims_q - 1'b1);
  end

  // loads
  logic           ld_ok;
  logic [EAW-1:0] wr_addr;
  logic [VW-1:0]  var_c;
  logic [WW-1:0]  wgt_c;

  assign ld_ok   = (32'(component_i) < MAX_COMPONENTS) && (32'(dimension_i) < MAX_DIMS);
  assign wr_addr = EAW'(32'(component_i) * MAX_DIMS + 32'(dimension_i));
  assign var_c   = (variance_i == '0) ? VW'(1) : variance_i;
  assign wgt_c   = (weight_i > gkm_pkg::ONE_Q16) ? gkm_pkg::ONE_Q16 : weight_i;

  logic [MW-1:0] om_mem [EDEP];
  logic [VW-1:0] ov_mem [EDEP];
  logic [MW-1:0] nm_mem [EDEP];
  logic [VW-1:0] nv_mem [EDEP];
  logic [WW-1:0] ow_q [MAX_COMPONENTS];
  logic [WW-1:0] nw_q [MAX_COMPONENTS];

  logic [CW-1:0]  bi_q, bj_q, oi, nj;
  logic [EAW-1:0] ra_o, ra_n;
  logic [MW-1:0]  m0_q, m1_q;
  logic [VW-1:0]  s0_q, s1_q;

  assign oi   = cmd_i.elem_best ? bi_q : ci_i;
  assign nj   = cmd_i.elem_best ? bj_q : cj_i;
  assign ra_o = EAW'(32'(oi) * MAX_DIMS + 32'(cd_i));
  assign ra_n = EAW'(32'(nj) * MAX_DIMS + 32'(cd_i));

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_old && ld_ok) begin
      om_mem[wr_addr] <= mean_i;
      ov_mem[wr_addr] <= var_c;
      if (dimension_i == 3'd0) ow_q[CW'(component_i)] <= wgt_c;
    end
    if (cmd_i.ld_new && ld_ok) begin
      nm_mem[wr_addr] <= mean_i;
      nv_mem[wr_addr] <= var_c;
      if (dimension_i == 3'd0) nw_q[CW'(component_i)] <= wgt_c;
    end
    if (cmd_i.elem_rd) begin
      m0_q <= om_mem[ra_o];
      s0_q <= ov_mem[ra_o];
      m1_q <= nm_mem[ra_n];
      s1_q <= nv_mem[ra_n];
    end
  end

  // element terms
  logic [VW-1:0]        s0c, s1c;
  logic signed [MW:0]   diff;
  logic [MW-1:0]        mag;

  assign s0c  = (s0_q == '0) ? VW'(1) : s0_q;
  assign s1c  = (s1_q == '0) ? VW'(1) : s1_q;
  assign diff = $signed({m1_q[MW-1], m1_q}) - $signed({m0_q[MW-1], m0_q});
  assign mag  = diff[MW] ? MW'(-diff) : diff[MW-1:0];

  // shared divider
  logic [NW-1:0]     div_num, quot;
  logic [DDW-1:0]    div_den;
  logic              div_done;
  logic [40:0]       a0_q, a1_q, s_q;
  logic [CNT_W1-1:0] cnt_q;

  always_comb begin
    case (cmd_i.div_op)
      gkm_pkg::DOP_A: begin
        div_num = {16'b0, s0c, 16'b0};
        div_den = DDW'(s1c);
      end
      gkm_pkg::DOP_B: begin
        div_num = 64'(mag) * 64'(mag);
        div_den = DDW'(s1c);
      end
      gkm_pkg::DOP_F: begin
        div_num = {a1_q[39:0], 24'b0};
        div_den = s_q;
      end
      gkm_pkg::DOP_W: begin
        div_num = NW'(s_q);
        div_den = DDW'(cnt_q);
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  gkm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_go),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  logic [KW-1:0] qcap;
  assign qcap = (|quot[NW-1:KW-1]) ? gkm_pkg::KL_CAP : quot[KW-1:0];

  // log unit
  logic          log_done;
  logic [LW-1:0] log_res, l1_q;

  gkm_log2 u_log (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.log_go),
    .x_i      (cmd_i.log_sel_s1 ? s1c : s0c),
    .done_o   (log_done),
    .result_o (log_res)
  );

  logic signed [LW:0] ld;
  logic [LW-1:0]      ld_mag;
  logic [LW+15:0]     cprod;

  assign ld     = $signed({1'b0, l1_q}) - $signed({1'b0, log_res});
  assign ld_mag = ld[LW] ? LW'(-ld) : ld[LW-1:0];
  assign cprod  = (LW+16)'(ld_mag) * (LW+16)'(gkm_pkg::LN2_Q16);

  // accumulation, table and search
  logic signed [KW-1:0] acc_q, cterm_q, best_q;
  logic [KW-1:0]        tab_mem [TDEP];
  logic [KW-1:0]        tab_q;
  logic                 rv_q, found_q;
  logic [CW-1:0]        ti_q, tj_q;
  logic [MAX_COMPONENTS-1:0] old_taken_q, new_taken_q;
  logic [TAW-1:0]       tab_addr;

  assign tab_addr = TAW'(32'(ci_i) * MAX_COMPONENTS + 32'(cj_i));

  always_ff @(posedge clk_i) begin
    if (cmd_i.log1_lat) l1_q <= log_res;
    if (cmd_i.c_mul) begin
      cterm_q <= ld[LW] ? -$signed(KW'(cprod[LW+15:16])) : $signed(KW'(cprod[LW+15:16]));
    end
    if (cmd_i.run_init || cmd_i.tab_wr) acc_q <= '0;
    else if (cmd_i.acc_add_div) acc_q <= cap_add(acc_q, $signed(qcap));
    else if (cmd_i.acc_add_c) acc_q <= cap_add(acc_q, cterm_q);
    if (cmd_i.tab_wr) tab_mem[tab_addr] <= acc_q;
    if (cmd_i.tab_rd) begin
      tab_q <= tab_mem[tab_addr];
      ti_q  <= ci_i;
      tj_q  <= cj_i;
    end
    if (rv_q && !old_taken_q[ti_q] && !new_taken_q[tj_q]
        && (!found_q || $signed(tab_q) < best_q)) begin
      best_q <= $signed(tab_q);
      bi_q   <= ti_q;
      bj_q   <= tj_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q        <= 1'b0;
      found_q     <= 1'b0;
      old_taken_q <= '0;
      new_taken_q <= '0;
    end else begin
      rv_q <= cmd_i.tab_rd;
      if (cmd_i.srch_clr) found_q <= 1'b0;
      else if (rv_q && !old_taken_q[ti_q] && !new_taken_q[tj_q]) found_q <= 1'b1;
      if (cmd_i.run_init) begin
        old_taken_q <= '0;
        new_taken_q <= '0;
      end else if (cmd_i.take) begin
        old_taken_q[bi_q] <= 1'b1;
        new_taken_q[bj_q] <= 1'b1;
      end
    end
  end

  // merge
  logic [FW-1:0]          f_q;
  logic [WW-1:0]          w_q;
  logic signed [MW+FW+1:0] pm_q, pv_q;
  logic signed [VW:0]     vdiff;
  logic signed [MW+2:0]   mm_sum, vv_sum;

  assign vdiff  = $signed({1'b0, s1_q}) - $signed({1'b0, s0_q});
  assign mm_sum = (MW+3)'($signed(m0_q)) + $signed(pm_q[MW+FW+1:24]);
  assign vv_sum = $signed({3'b000, s0_q}) + $signed(pv_q[MW+FW+1:24]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_w) begin
      a0_q <= 41'(old_count_q) * 41'(ow_q[bi_q]);
      a1_q <= 41'(new_count_q) * 41'(nw_q[bj_q]);
    end
    if (cmd_i.sum_s) begin
      s_q   <= a0_q + a1_q;
      cnt_q <= CNT_W1'(old_count_q) + CNT_W1'(new_count_q);
    end
    if (cmd_i.f_half) f_q <= gkm_pkg::HALF_Q24;
    else if (cmd_i.f_lat) f_q <= quot[FW-1:0];
    if (cmd_i.w_zero) w_q <= '0;
    else if (cmd_i.w_lat) w_q <= quot[WW-1:0];
    if (cmd_i.prod_mul) begin
      pm_q <= diff * $signed({1'b0, f_q});
      pv_q <= vdiff * $signed({1'b0, f_q});
    end
  end

  // result beat register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      merged_index_o    <= 3'(ck_i);
      out_dimension_o   <= 3'(cd_i);
      merged_mean_o     <= mm_sum[MW-1:0];
      merged_variance_o <= vv_sum[VW-1:0];
      merged_weight_o   <= w_q;
      last_o            <= cmd_i.out_last;
    end
  end

  assign out_valid_o = out_valid_q;

  assign status_o.div_done = div_done;
  assign status_o.log_done = log_done;
  assign status_o.s_zero   = (s_q == '0);
  assign status_o.cnt_zero = (cnt_q == '0);
  assign status_o.out_free = !out_valid_q || !out_stall_i;

endmodule

FILE: src/gkm_ctrl.sv
// ---------------------------------------------------------------------------
// gkm_ctrl
// Sequencer: loads, divergence table fill, greedy search, merge beats.
// ---------------------------------------------------------------------------
module gkm_ctrl #(
  parameter int MAX_COMPONENTS = 8,
  parameter int MAX_DIMS       = 8,
  localparam int CW  = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1,
  localparam int DIW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       action_i,
  input  gkm_pkg::status_t status_i,
  input  logic [CW-1:0]    k_last_i,
  input  logic [DIW-1:0]   d_last_i,
  output gkm_pkg::cmd_t    cmd_o,
  output logic [CW-1:0]    ci_o,
  output logic [CW-1:0]    cj_o,
  output logic [CW-1:0]    ck_o,
  output logic [DIW-1:0]   cd_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_INIT, S_RD, S_A_GO, S_A_WT, S_B_GO, S_B_WT,
    S_L1_GO, S_L1_WT, S_L0_GO, S_L0_WT, S_CADD, S_WR,
    S_SINIT, S_SRCH, S_SDRN, S_TAKE, S_MW, S_MS,
    S_F_GO, S_F_WT, S_W_GO, S_W_WT, S_MRD, S_MMUL, S_MOUT
  } state_e;

  state_e         state_q;
  logic [CW-1:0]  ci_q, cj_q, ck_q;
  logic [DIW-1:0] cd_q;
  logic           accept;
  logic           d_end, k_end;

  assign accept = in_valid_i && (state_q == S_IDLE);
  assign d_end  = (cd_q == d_last_i);
  assign k_end  = (ck_q == k_last_i);

  always_comb begin
    cmd_o = '0;
    case (state_q)
      S_IDLE: begin
        cmd_o.ld_old = accept && (action_i == gkm_pkg::ACT_LOAD_OLD);
        cmd_o.ld_new = accept && (action_i == gkm_pkg::ACT_LOAD_NEW);
      end
      S_INIT:  cmd_o.run_init = 1'b1;
      S_RD:    cmd_o.elem_rd = 1'b1;
      S_A_GO: begin
        cmd_o.div_go = 1'b1;
        cmd_o.div_op = gkm_pkg::DOP_A;
      end
      S_A_WT:  cmd_o.acc_add_div = status_i.div_done;
      S_B_GO: begin
        cmd_o.div_go = 1'b1;
        cmd_o.div_op = gkm_pkg::DOP_B;
      end
      S_B_WT:  cmd_o.acc_add_div = status_i.div_done;
      S_L1_GO: begin
        cmd_o.log_go     = 1'b1;
        cmd_o.log_sel_s1 = 1'b1;
      end
      S_L1_WT: cmd_o.log1_lat = status_i.log_done;
      S_L0_GO: cmd_o.log_go = 1'b1;
      S_L0_WT: cmd_o.c_mul = status_i.log_done;
      S_CADD:  cmd_o.acc_add_c = 1'b1;
      S_WR:    cmd_o.tab_wr = 1'b1;
      S_SINIT: cmd_o.srch_clr = 1'b1;
      S_SRCH:  cmd_o.tab_rd = 1'b1;
      S_SDRN:  ;
      S_TAKE:  cmd_o.take = 1'b1;
      S_MW:    cmd_o.mul_w = 1'b1;
      S_MS:    cmd_o.sum_s = 1'b1;
      S_F_GO: begin
        cmd_o.f_half = status_i.s_zero;
        cmd_o.div_go = !status_i.s_zero;
        cmd_o.div_op = gkm_pkg::DOP_F;
      end
      S_F_WT:  cmd_o.f_lat = status_i.div_done;
      S_W_GO: begin
        cmd_o.w_zero = status_i.cnt_zero;
        cmd_o.div_go = !status_i.cnt_zero;
        cmd_o.div_op = gkm_pkg::DOP_W;
      end
      S_W_WT:  cmd_o.w_lat = status_i.div_done;
      S_MRD: begin
        cmd_o.elem_rd   = 1'b1;
        cmd_o.elem_best = 1'b1;
      end
      S_MMUL:  cmd_o.prod_mul = 1'b1;
      S_MOUT: begin
        cmd_o.out_load = status_i.out_free;
        cmd_o.out_last = k_end && d_end;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ci_q    <= '0;
      cj_q    <= '0;
      ck_q    <= '0;
      cd_q    <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept && action_i == gkm_pkg::ACT_START) state_q <= S_INIT;
        end
        S_INIT: begin
          ci_q    <= '0;
          cj_q    <= '0;
          cd_q    <= '0;
          state_q <= S_RD;
        end
        S_RD:    state_q <= S_A_GO;
        S_A_GO:  state_q <= S_A_WT;
        S_A_WT:  if (status_i.div_done) state_q <= S_B_GO;
        S_B_GO:  state_q <= S_B_WT;
        S_B_WT:  if (status_i.div_done) state_q <= S_L1_GO;
        S_L1_GO: state_q <= S_L1_WT;
        S_L1_WT: if (status_i.log_done) state_q <= S_L0_GO;
        S_L0_GO: state_q <= S_L0_WT;
        S_L0_WT: if (status_i.log_done) state_q <= S_CADD;
        S_CADD: begin
          if (d_end) begin
            state_q <= S_WR;
          end else begin
            cd_q    <= cd_q + 1'b1;
            state_q <= S_RD;
          end
        end
        S_WR: begin
          cd_q    <= '0;
          state_q <= S_RD;
          if (cj_q == k_last_i) begin
            cj_q <= '0;
            if (ci_q == k_last_i) begin
              ck_q    <= '0;
              state_q <= S_SINIT;
            end else begin
              ci_q <= ci_q + 1'b1;
            end
          end else begin
            cj_q <= cj_q + 1'b1;
          end
        end
        S_SINIT: begin
          ci_q    <= '0;
          cj_q    <= '0;
          state_q <= S_SRCH;
        end
        S_SRCH: begin
          // new index outer, old index inner
          if (ci_q == k_last_i) begin
            ci_q <= '0;
            if (cj_q == k_last_i) state_q <= S_SDRN;
            else cj_q <= cj_q + 1'b1;
          end else begin
            ci_q <= ci_q + 1'b1;
          end
        end
        S_SDRN:  state_q <= S_TAKE;
        S_TAKE:  state_q <= S_MW;
        S_MW:    state_q <= S_MS;
        S_MS:    state_q <= S_F_GO;
        S_F_GO:  state_q <= status_i.s_zero ? S_W_GO : S_F_WT;
        S_F_WT:  if (status_i.div_done) state_q <= S_W_GO;
        S_W_GO: begin
          cd_q    <= '0;
          state_q <= status_i.cnt_zero ? S_MRD : S_W_WT;
        end
        S_W_WT:  if (status_i.div_done) state_q <= S_MRD;
        S_MRD:   state_q <= S_MMUL;
        S_MMUL:  state_q <= S_MOUT;
        S_MOUT: begin
          if (status_i.out_free) begin
            if (d_end) begin
              if (k_end) begin
                state_q <= S_IDLE;
              end else begin
                ck_q    <= ck_q + 1'b1;
                state_q <= S_SINIT;
              end
            end else begin
              cd_q    <= cd_q + 1'b1;
              state_q <= S_MRD;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign ci_o = ci_q;
  assign cj_o = cj_q;
  assign ck_o = ck_q;
  assign cd_o = cd_q;

endmodule

FILE: src/gmm_kl_greedy_merge.sv
// ---------------------------------------------------------------------------
// gmm_kl_greedy_merge
// Greedy pairing of an old and a new diagonal gaussian mixture by a
// simplified kl divergence, with weighted merge of each chosen pair.
// ---------------------------------------------------------------------------
//
//   channel  | direction | handshake                 | beat contents
//   ---------+-----------+---------------------------+-------------------------------
//   in       | in        | in_valid_i / in_stall_o   | action, component, dimension,
//            |           |                           | mean, variance, weight
//   out      | out       | out_valid_o / out_stall_i | merged index, dimension, mean,
//            |           |                           | variance, weight, last
//   cfg      | in        | cfg_we_i                  | register index, write data
//
// a load beat is taken without a stall; the block is ready again on the next cycle
// a start beat fills the K*K divergence table: each of the K*K*D element
//   terms runs the shared divider twice and the serial log2 unit twice
// the merge then takes per chosen pair a K*K table search, up to two divides and
//   per beat a read, multiply and load; input stalls until the last beat is loaded
// the mixture stores and the table have no reset and no clearing pass
// ---------------------------------------------------------------------------
module gmm_kl_greedy_merge #(
  parameter int MAX_COMPONENTS = 8,
  parameter int MAX_DIMS       = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input beats
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         action_i,
  input  logic [2:0]                         component_i,
  input  logic [2:0]                         dimension_i,
  input  logic signed [gkm_pkg::MEAN_W-1:0]  mean_i,
  input  logic [gkm_pkg::VAR_W-1:0]          variance_i,
  input  logic [gkm_pkg::WGT_W-1:0]          weight_i,
  // result beats
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [2:0]                         merged_index_o,
  output logic [2:0]                         out_dimension_o,
  output logic signed [gkm_pkg::MEAN_W-1:0]  merged_mean_o,
  output logic [gkm_pkg::VAR_W-1:0]          merged_variance_o,
  output logic [gkm_pkg::WGT_W-1:0]          merged_weight_o,
  output logic                               last_o,
  // configuration writes
  input  logic                               cfg_we_i,
  input  logic [1:0]                         cfg_index_i,
  input  logic [gkm_pkg::CNT_W-1:0]          cfg_data_i
);

  localparam int CW  = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
  localparam int DIW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

  gkm_pkg::cmd_t    cmd;
  gkm_pkg::status_t status;
  logic [CW-1:0]    ci, cj, ck, k_last;
  logic [DIW-1:0]   cd, d_last;

  // sequencer: owns the component and dimension loop counters
  gkm_ctrl #(
    .MAX_COMPONENTS (MAX_COMPONENTS),
    .MAX_DIMS       (MAX_DIMS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .action_i   (action_i),
    .status_i   (status),
    .k_last_i   (k_last),
    .d_last_i   (d_last),
    .cmd_o      (cmd),
    .ci_o       (ci),
    .cj_o       (cj),
    .ck_o       (ck),
    .cd_o       (cd)
  );

  // datapath: stores, divider, log2, table, search and result register
  gkm_dp #(
    .MAX_COMPONENTS (MAX_COMPONENTS),
    .MAX_DIMS       (MAX_DIMS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .ci_i              (ci),
    .cj_i              (cj),
    .ck_i              (ck),
    .cd_i              (cd),
    .status_o          (status),
    .k_last_o          (k_last),
    .d_last_o          (d_last),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .component_i       (component_i),
    .dimension_i       (dimension_i),
    .mean_i            (mean_i),
    .variance_i        (variance_i),
    .weight_i          (weight_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .merged_index_o    (merged_index_o),
    .out_dimension_o   (out_dimension_o),
    .merged_mean_o     (merged_mean_o),
    .merged_variance_o (merged_variance_o),
    .merged_weight_o   (merged_weight_o),
    .last_o            (last_o)
  );

  // a result beat only appears while a merge run holds off the input
  a_out_from_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result beat appeared outside a merge run");

  // a start beat always begins a run
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && action_i == gkm_pkg::ACT_START) |=> in_stall_o)
    else $error("start beat did not begin a run");

  // load beats never stall the input
  a_load_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o &&
     (action_i == gkm_pkg::ACT_LOAD_OLD || action_i == gkm_pkg::ACT_LOAD_NEW))
    |=> !in_stall_o)
    else $error("load beat stalled the input");

endmodule

FILE: bench/gmm_kl_greedy_merge_tb.sv
// ---------------------------------------------------------------------------
// gmm_kl_greedy_merge_tb
// Loads old and new mixtures, starts greedy merges under several settings
// of the counts and sizes, and checks every merged beat against a local
// fixed-point model of the divergence order and the weighted merge.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module gmm_kl_greedy_merge_tb;

  localparam int NC = 8;
  localparam int ND = 8;
  localparam logic [63:0] DIV_CAP = 64'h0000_7FFF_FFFF_FFFF;

  typedef struct {
    gkm_pkg::action_e   act;
    logic [2:0]         comp;
    logic [2:0]         dim;
    logic signed [31:0] mean;
    logic [31:0]        var_q;
    logic [16:0]        wgt;
  } load_beat_t;

  typedef struct {
    logic [2:0]         rank;
    logic [2:0]         dim;
    logic signed [31:0] mean;
    logic [31:0]        var_q;
    logic [16:0]        wgt;
    logic               tail;
  } merge_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // input channel
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         action_i = gkm_pkg::ACT_NONE;
  logic [2:0]         component_i = '0;
  logic [2:0]         dimension_i = '0;
  logic signed [31:0] mean_i = '0;
  logic [31:0]        variance_i = 32'd1;
  logic [16:0]        weight_i = '0;
  // output channel
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [2:0]         merged_index_o;
  logic [2:0]         out_dimension_o;
  logic signed [31:0] merged_mean_o;
  logic [31:0]        merged_variance_o;
  logic [16:0]        merged_weight_o;
  logic               last_o;
  // configuration
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_index_i = '0;
  logic [23:0]        cfg_data_i = '0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  gmm_kl_greedy_merge dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .action_i, .component_i, .dimension_i,
    .mean_i, .variance_i, .weight_i,
    .out_valid_o, .out_stall_i, .merged_index_o, .out_dimension_o,
    .merged_mean_o, .merged_variance_o, .merged_weight_o, .last_o,
    .cfg_we_i, .cfg_index_i, .cfg_data_i
  );

  // model copy of the stores and registers
  logic signed [31:0] m_old_mean [NC*ND];
  logic [31:0]        m_old_var  [NC*ND];
  logic signed [31:0] m_new_mean [NC*ND];
  logic [31:0]        m_new_var  [NC*ND];
  logic [16:0]        m_old_wgt  [NC];
  logic [16:0]        m_new_wgt  [NC];
  logic [23:0]        m_old_cnt = '0;
  logic [23:0]        m_new_cnt = '0;
  logic [3:0]         m_comps = 4'd8;
  logic [3:0]         m_dims = 4'd8;

  load_beat_t  pending_beats[$];
  merge_beat_t expected_merges[$];

  int  errors = 0;
  int  starts_seen = 0;
  int  beats_checked = 0;
  int  items_sent = 0;
  bit  quiet = 1'b0;      // no idling in the last part of the run
  bit  in_taken = 1'b0;
  int  send_gap = 0;
  int  stall_left = 0;

  function automatic int clamp_size(input logic [3:0] v, input int mx);
    if (v < 1) return 1;
    if (v > mx) return mx;
    return int'(v);
  endfunction

  // log2 of a raw Q16.16 value, 16 fraction bits by repeated squaring
  function automatic logic [20:0] log2_fix(input logic [31:0] x);
    int          p;
    logic [63:0] y;
    logic [15:0] fr;
    if (x == 0) x = 32'd1;
    p = 31;
    while (!x[p]) p--;
    y = {32'b0, x} << (31 - p);
    fr = '0;
    for (int i = 0; i < 16; i++) begin
      y = (y * y) >> 31;
      fr = {fr[14:0], 1'b0};
      if (y >= 64'h1_0000_0000) begin
        y = y >> 1;
        fr[0] = 1'b1;
      end
    end
    return {p[4:0], fr};
  endfunction

  function automatic longint sat_add(input longint acc, input longint t);
    acc = acc + t;
    return (acc > longint'(DIV_CAP)) ? longint'(DIV_CAP) : acc;
  endfunction

  function automatic longint pair_divergence(input int i, input int j, input int dims);
    longint      acc, diff, ld, c;
    logic [31:0] s0, s1;
    logic [63:0] t, mag;
    acc = 0;
    for (int d = 0; d < dims; d++) begin
      s0 = m_old_var[i*ND+d];
      s1 = m_new_var[j*ND+d];
      if (s0 == 0) s0 = 32'd1;
      if (s1 == 0) s1 = 32'd1;
      diff = longint'(m_new_mean[j*ND+d]) - longint'(m_old_mean[i*ND+d]);
      t = ({32'b0, s0} << 16) / {32'b0, s1};
      acc = sat_add(acc, (t > DIV_CAP) ? longint'(DIV_CAP) : longint'(t));
      mag = (diff < 0) ? 64'(-diff) : 64'(diff);
      t = (mag * mag) / {32'b0, s1};         // square of a 32-bit magnitude fits
      acc = sat_add(acc, (t > DIV_CAP) ? longint'(DIV_CAP) : longint'(t));
      ld = longint'({43'b0, log2_fix(s1)}) - longint'({43'b0, log2_fix(s0)});
      mag = (ld < 0) ? 64'(-ld) : 64'(ld);
      c = longint'((mag * 64'd45426) >> 16);
      acc = sat_add(acc, (ld < 0) ? -c : c);
    end
    return acc;
  endfunction

  // predicted effect of one accepted input beat
  task automatic predict_merge(input load_beat_t b);
    int          nk, nd, bi, bj, at;
    longint      tab [NC*NC];
    longint      best, mm, vv;
    logic [7:0]  old_used, new_used;
    logic [63:0] a0, a1, s, f, cnt, w;
    logic [31:0] v;
    logic [16:0] wg;
    bit          found;
    merge_beat_t r;
    if (b.act == gkm_pkg::ACT_LOAD_OLD || b.act == gkm_pkg::ACT_LOAD_NEW) begin
      at = int'(b.comp) * ND + int'(b.dim);
      v = (b.var_q == 0) ? 32'd1 : b.var_q;
      wg = (b.wgt > 17'h10000) ? 17'h10000 : b.wgt;
      if (b.act == gkm_pkg::ACT_LOAD_OLD) begin
        m_old_mean[at] = b.mean;
        m_old_var[at] = v;
        if (b.dim == 0) m_old_wgt[b.comp] = wg;
      end else begin
        m_new_mean[at] = b.mean;
        m_new_var[at] = v;
        if (b.dim == 0) m_new_wgt[b.comp] = wg;
      end
      return;
    end
    if (b.act != gkm_pkg::ACT_START) return;
    starts_seen++;
    nk = clamp_size(m_comps, NC);
    nd = clamp_size(m_dims, ND);
    for (int i = 0; i < nk; i++)
      for (int j = 0; j < nk; j++) tab[i*NC+j] = pair_divergence(i, j, nd);
    old_used = '0;
    new_used = '0;
    for (int k = 0; k < nk; k++) begin
      found = 1'b0;
      best = 0;
      bi = 0;
      bj = 0;
      // scan new index outermost so ties land on the lowest new, then old
      for (int j = 0; j < nk; j++) begin
        if (new_used[j]) continue;
        for (int i = 0; i < nk; i++) begin
          if (old_used[i]) continue;
          if (!found || tab[i*NC+j] < best) begin
            best = tab[i*NC+j];
            bi = i;
            bj = j;
            found = 1'b1;
          end
        end
      end
      old_used[bi] = 1'b1;
      new_used[bj] = 1'b1;
      a0 = 64'(m_old_cnt) * 64'(m_old_wgt[bi]);
      a1 = 64'(m_new_cnt) * 64'(m_new_wgt[bj]);
      s = a0 + a1;
      f = (s != 0) ? (a1 << 24) / s : 64'h80_0000;
      cnt = 64'(m_old_cnt) + 64'(m_new_cnt);
      w = (cnt != 0) ? s / cnt : 64'd0;
      for (int d = 0; d < nd; d++) begin
        mm = longint'(m_old_mean[bi*ND+d]) +
             (((longint'(m_new_mean[bj*ND+d]) - longint'(m_old_mean[bi*ND+d]))
               * longint'(f)) >>> 24);
        vv = longint'({32'b0, m_old_var[bi*ND+d]}) +
             (((longint'({32'b0, m_new_var[bj*ND+d]}) -
                longint'({32'b0, m_old_var[bi*ND+d]})) * longint'(f)) >>> 24);
        r.rank = k[2:0];
        r.dim = d[2:0];
        r.mean = mm[31:0];
        r.var_q = vv[31:0];
        r.wgt = w[16:0];
        r.tail = (k == nk - 1) && (d == nd - 1);
        expected_merges.insert(expected_merges.size(), r);
      end
    end
  endtask

  // driver: next beat at the falling edge once the current one is taken
  always @(negedge clk_i) begin
    if (!in_valid_i || in_taken) begin
      if (send_gap > 0) begin
        in_valid_i <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_beats.size() > 0) begin
        load_beat_t b;
        b = pending_beats.pop_front();
        action_i <= b.act;
        component_i <= b.comp;
        dimension_i <= b.dim;
        mean_i <= b.mean;
        variance_i <= b.var_q;
        weight_i <= b.wgt;
        in_valid_i <= 1'b1;
        if (!quiet && $urandom_range(0, 6) == 0) send_gap <= $urandom_range(1, 10);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver stall bursts
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      out_stall_i <= 1'b1;
      stall_left <= $urandom_range(0, 9);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // monitor: model on input beats, compare output beats
  always @(posedge clk_i) begin
    load_beat_t  b;
    merge_beat_t e;
    in_taken <= in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      b.act = gkm_pkg::action_e'(action_i);
      b.comp = component_i;
      b.dim = dimension_i;
      b.mean = mean_i;
      b.var_q = variance_i;
      b.wgt = weight_i;
      predict_merge(b);
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_merges.size() == 0) begin
        $error("merged beat with nothing pending: index %0d dim %0d",
               merged_index_o, out_dimension_o);
        errors++;
      end else begin
        e = expected_merges.pop_front();
        beats_checked++;
        if (merged_index_o !== e.rank) begin
          $error("merged_index exp %0d got %0d", e.rank, merged_index_o);
          errors++;
        end
        if (out_dimension_o !== e.dim) begin
          $error("out_dimension exp %0d got %0d", e.dim, out_dimension_o);
          errors++;
        end
        if (merged_mean_o !== e.mean) begin
          $error("merged_mean exp %0d got %0d", e.mean, merged_mean_o);
          errors++;
        end
        if (merged_variance_o !== e.var_q) begin
          $error("merged_variance exp %0d got %0d", e.var_q, merged_variance_o);
          errors++;
        end
        if (merged_weight_o !== e.wgt) begin
          $error("merged_weight exp %0d got %0d", e.wgt, merged_weight_o);
          errors++;
        end
        if (last_o !== e.tail) begin
          $error("last exp %0d got %0d", e.tail, last_o);
          errors++;
        end
      end
    end
  end

  function automatic logic signed [31:0] pick_mean();
    case ($urandom_range(0, 3))
      0: return 32'sd65536 * ($urandom_range(0, 2) - 1);
      1: return $urandom;
      2: return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sd524288;
      default: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    endcase
  endfunction

  function automatic logic [31:0] pick_var();
    case ($urandom_range(0, 3))
      0: return 32'd65536;
      1: return $urandom;
      2: return $urandom_range(1, 32'h0010_0000);
      default: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
    endcase
  endfunction

  function automatic logic [16:0] pick_wgt();
    case ($urandom_range(0, 2))
      0: return 17'h10000;
      1: return 17'($urandom_range(0, 65536));
      default: return 17'($urandom_range(0, 17'h1FFFF));
    endcase
  endfunction

  task automatic queue_beat(input gkm_pkg::action_e a, input int c, input int d,
                            input logic signed [31:0] m, input logic [31:0] v,
                            input logic [16:0] w);
    load_beat_t b;
    b.act = a;
    b.comp = c[2:0];
    b.dim = d[2:0];
    b.mean = m;
    b.var_q = v;
    b.wgt = w;
    pending_beats.insert(pending_beats.size(), b);
    items_sent++;
  endtask

  // block is idle: nothing queued, nothing in flight, nothing owed
  task automatic drain();
    while (pending_beats.size() > 0 || in_valid_i || expected_merges.size() > 0)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      gkm_pkg::CFG_OLD_COUNT:  m_old_cnt = val;
      gkm_pkg::CFG_NEW_COUNT:  m_new_cnt = val;
      gkm_pkg::CFG_COMPONENTS: m_comps = val[3:0];
      gkm_pkg::CFG_DIMS:       m_dims = val[3:0];
      default: ;
    endcase
  endtask

  task automatic set_all(input logic [23:0] oc, input logic [23:0] nc,
                         input logic [3:0] k, input logic [3:0] d);
    write_reg(gkm_pkg::CFG_OLD_COUNT, oc);
    write_reg(gkm_pkg::CFG_NEW_COUNT, nc);
    write_reg(gkm_pkg::CFG_COMPONENTS, {20'b0, k});
    write_reg(gkm_pkg::CFG_DIMS, {20'b0, d});
  endtask

  task automatic pick_counts(output logic [23:0] oc, output logic [23:0] nc);
    case ($urandom_range(0, 3))
      0: begin oc = 24'hFF_FFFF; nc = 24'($urandom_range(0, 24'hFF_FFFF)); end
      1: begin oc = 24'($urandom_range(0, 1000)); nc = 24'($urandom_range(0, 1000)); end
      2: begin oc = 24'($urandom); nc = 24'($urandom); end
      default: begin oc = '0; nc = $urandom_range(0, 1) ? 24'd0 : 24'hFF_FFFF; end
    endcase
  endtask

  initial begin
    logic [23:0] oc, nc;
    logic [3:0]  kr, dr;
    int          nk, nd, extra;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: sizes below one act as one, zero counts, weight and variance
    // clamps, mean and variance extremes, the unused action
    set_all(24'd0, 24'd0, 4'd0, 4'd0);
    queue_beat(gkm_pkg::ACT_LOAD_OLD, 0, 0, 32'sh8000_0000, 32'd0, 17'h1FFFF);
    queue_beat(gkm_pkg::ACT_LOAD_NEW, 0, 0, 32'sh7FFF_FFFF, 32'hFFFF_FFFF, 17'd0);
    queue_beat(gkm_pkg::ACT_NONE, 7, 7, 32'sd0, 32'hFFFF_FFFF, 17'h1FFFF);
    queue_beat(gkm_pkg::ACT_START, 0, 0, 32'sd0, 32'd1, 17'd0);
    drain();

    // directed: identical pairs force ties, maximum counts, old weight zero
    set_all(24'hFF_FFFF, 24'hFF_FFFF, 4'd2, 4'd1);
    for (int c = 0; c < 2; c++) begin
      queue_beat(gkm_pkg::ACT_LOAD_OLD, c, 0, 32'sd65536, 32'd65536, 17'd0);
      queue_beat(gkm_pkg::ACT_LOAD_NEW, c, 0, 32'sd65536, 32'd65536, 17'h10000);
    end
    queue_beat(gkm_pkg::ACT_START, 0, 0, 32'sd0, 32'd1, 17'd0);
    drain();

    // one side empty: zero old count with non-zero new weights
    write_reg(gkm_pkg::CFG_OLD_COUNT, 24'd0);
    queue_beat(gkm_pkg::ACT_START, 0, 0, 32'sd0, 32'd1, 17'd0);
    drain();

    // full-size load, sizes above the maximum act as the maximum
    pick_counts(oc, nc);
    set_all(oc, nc, 4'd15, 4'd15);
    for (int a = 0; a < 2; a++)
      for (int c = 0; c < NC; c++)
        for (int d = 0; d < ND; d++)
          queue_beat(a ? gkm_pkg::ACT_LOAD_NEW : gkm_pkg::ACT_LOAD_OLD, c, d,
                     pick_mean(), pick_var(), pick_wgt());
    queue_beat(gkm_pkg::ACT_START, 0, 0, pick_mean(), pick_var(), pick_wgt());
    drain();

    // random phases: every entry is written now, so partial reloads are safe
    while (items_sent < 310) begin
      if (items_sent > 270) quiet = 1'b1;
      pick_counts(oc, nc);
      if ($urandom_range(0, 7) == 0) begin
        kr = $urandom_range(0, 1) ? 4'd8 : 4'($urandom_range(9, 15));
        dr = 4'($urandom_range(0, 2));
      end else begin
        kr = 4'($urandom_range(1, 3));
        dr = 4'($urandom_range(1, 3));
      end
      set_all(oc, nc, kr, dr);
      nk = clamp_size(kr, NC);
      nd = clamp_size(dr, ND);
      extra = $urandom_range(2, 14);
      for (int n = 0; n < extra; n++) begin
        if ($urandom_range(0, 9) == 0)
          queue_beat(gkm_pkg::ACT_NONE, $urandom_range(0, 7), $urandom_range(0, 7),
                     pick_mean(), pick_var(), pick_wgt());
        else
          queue_beat($urandom_range(0, 1) ? gkm_pkg::ACT_LOAD_NEW : gkm_pkg::ACT_LOAD_OLD,
                     $urandom_range(0, nk - 1), $urandom_range(0, nd - 1),
                     pick_mean(), pick_var(), pick_wgt());
      end
      queue_beat(gkm_pkg::ACT_START, 0, 0, pick_mean(), pick_var(), pick_wgt());
      if ($urandom_range(0, 2) == 0)
        queue_beat(gkm_pkg::ACT_START, 0, 0, pick_mean(), pick_var(), pick_wgt());
      drain();
    end

    repeat (100) @(posedge clk_i);
    $display("covered %0d input beats, %0d merge starts, %0d merged beats checked",
             items_sent, starts_seen, beats_checked);
    if (errors == 0 && expected_merges.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d merged beats outstanding", expected_merges.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
